### rtl/bqsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqsm_pkg
// Shared types and constants of the bounded queue service monitor.
// ----------------------------------------------------------------------------
package bqsm_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int OccW       = $clog2(QueueDepth + 1);
  localparam int LimitW     = 5;
  localparam int CmpW       = (OccW > LimitW) ? OccW : LimitW;
  localparam int StampW     = 32;
  localparam int SvcW       = 8;
  localparam int CountW     = 32;
  localparam int SumW       = 40;
  localparam int LenW       = 5;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(10);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic            arrival;
    logic [SvcW-1:0] service_ticks;
  } in_t;

  typedef struct packed {
    logic [LenW-1:0]   queue_length;
    logic              started_service;
    logic [CountW-1:0] accepted_count;
    logic [CountW-1:0] served_count;
    logic [CountW-1:0] turned_away_count;
    logic [SumW-1:0]   length_sum;
    logic [SumW-1:0]   wait_sum;
  } out_t;

  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [SvcW-1:0]   service;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [PtrW-1:0]   addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic              exec;
    in_t               item;
    logic [LimitW-1:0] limit;
  } step_req_t;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

endpackage : bqsm_pkg
`default_nettype wire

### rtl/bqsm_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqsm_store
// Entry store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bqsm_store (
  input  logic              clk_i,
  input  bqsm_pkg::ram_wr_t wr_i,
  input  logic [bqsm_pkg::PtrW-1:0] rd_addr_i,
  output bqsm_pkg::entry_t  rd_data_o
);
  import bqsm_pkg::*;

  entry_t mem [QueueDepth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule : bqsm_store
`default_nettype wire

### rtl/bqsm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqsm_core
// Queue pointers, server countdown and statistics; one tick per exec cycle.
// ----------------------------------------------------------------------------
module bqsm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bqsm_pkg::step_req_t req_i,
  input  bqsm_pkg::entry_t    head_i,
  output logic [bqsm_pkg::PtrW-1:0] rd_addr_o,
  output bqsm_pkg::ram_wr_t   wr_o,
  output bqsm_pkg::out_t      result_o
);
  import bqsm_pkg::*;

  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [OccW-1:0]   occ_q, occ_d, occ_push;
  logic [StampW-1:0] tick_q, tick_d;
  logic [SvcW-1:0]   cd_q, cd_d, cd_load;
  logic [CountW-1:0] acc_q, acc_d, srv_q, srv_d, rej_q, rej_d;
  logic [SumW-1:0]   len_q, len_d, wait_q, wait_d;

  logic [CmpW-1:0]   lim_ext, lim_eff;
  logic              full, push, pop;
  entry_t            head_ent, new_ent;
  logic [StampW-1:0] waited;
  logic [SumW:0]     len_sum, wait_sum_w;

  always_comb begin
    lim_ext = CmpW'(req_i.limit);
    lim_eff = (lim_ext > CmpW'(QueueDepth)) ? CmpW'(QueueDepth) : lim_ext;
    full    = CmpW'(occ_q) >= lim_eff;
    push    = req_i.item.arrival && !full;
    occ_push = push ? occ_q + OccW'(1) : occ_q;
    pop     = (cd_q == '0) && (occ_push != '0);

    new_ent.stamp   = tick_q;
    new_ent.service = req_i.item.service_ticks;
    // An entry pushed into an empty queue is popped on the same tick, if the
    // server is free, before it reaches the store; it is then taken straight from the input.
    head_ent = (occ_q == '0) ? new_ent : head_i;

    occ_d  = pop ? occ_push - OccW'(1) : occ_push;
    head_d = pop ? next_ptr(head_q) : head_q;
    tail_d = push ? next_ptr(tail_q) : tail_q;

    cd_load = pop ? head_ent.service : cd_q;
    cd_d    = (cd_load == '0) ? '0 : cd_load - SvcW'(1);

    waited     = tick_q - head_ent.stamp;
    wait_sum_w = {1'b0, wait_q} + (SumW + 1)'(waited);
    wait_d     = !pop ? wait_q : (wait_sum_w[SumW] ? '1 : wait_sum_w[SumW-1:0]);

    len_sum = {1'b0, len_q} + (SumW + 1)'(occ_d);
    len_d   = len_sum[SumW] ? '1 : len_sum[SumW-1:0];

    acc_d  = (push && acc_q != '1) ? acc_q + CountW'(1) : acc_q;
    rej_d  = (req_i.item.arrival && full && rej_q != '1) ? rej_q + CountW'(1) : rej_q;
    srv_d  = (pop && srv_q != '1) ? srv_q + CountW'(1) : srv_q;
    tick_d = (tick_q != '1) ? tick_q + StampW'(1) : tick_q;

    wr_o.en   = req_i.exec && push;
    wr_o.addr = tail_q;
    wr_o.data = new_ent;

    result_o.queue_length      = LenW'(occ_d);
    result_o.started_service   = pop;
    result_o.accepted_count    = acc_d;
    result_o.served_count      = srv_d;
    result_o.turned_away_count = rej_d;
    result_o.length_sum        = len_d;
    result_o.wait_sum          = wait_d;
  end

  assign rd_addr_o = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
      tick_q <= '0;
      cd_q   <= '0;
      acc_q  <= '0;
      srv_q  <= '0;
      rej_q  <= '0;
      len_q  <= '0;
      wait_q <= '0;
    end else if (req_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
      tick_q <= tick_d;
      cd_q   <= cd_d;
      acc_q  <= acc_d;
      srv_q  <= srv_d;
      rej_q  <= rej_d;
      len_q  <= len_d;
      wait_q <= wait_d;
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(QueueDepth))
    else $error("queue occupancy above store depth");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.exec && cd_q != '0) |-> !pop)
    else $error("entry started service while server busy");

  a_tick_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.exec |=> tick_q >= $past(tick_q))
    else $error("tick counter went backwards");

endmodule : bqsm_core
`default_nettype wire

### rtl/bounded_queue_service_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_queue_service_monitor
// Tick-driven single-server queue monitor with a bounded entry store.
// ----------------------------------------------------------------------------
//
//   channel   | ports                              | handshake
//   ----------+------------------------------------+------------------------------
//   input     | start, busy, item_i                | beat taken when start && !busy
//   result    | strobe, result_o                   | valid for one cycle, no stall
//   config    | cfg_we_i, cfg_data_i               | written on any cycle with we
//
// Each tick goes through an update: in the cycle after acceptance the head entry comes
// out of the synchronous store, and the update of pointers, countdown and
// counters is done in that cycle. The result appears on the following cycle,
// in which the next beat may already be accepted; no beat is taken while the
// update is in progress (busy). The registered read of the store sets this order.
// Reset clears all counters, pointers and the countdown and sets the queue
// limit to ten; the entry store is not cleared, only written entries are read.
// The receiver cannot stall, so a result is never held back.
// ----------------------------------------------------------------------------
module bounded_queue_service_monitor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bqsm_pkg::in_t       item_i,
  output logic                strobe,
  output bqsm_pkg::out_t      result_o,
  input  logic                cfg_we_i,
  input  logic [bqsm_pkg::LimitW-1:0] cfg_data_i
);
  import bqsm_pkg::*;

  state_e            state_q, state_d;
  in_t               item_q;
  logic [LimitW-1:0] limit_q;
  out_t              result_q;
  logic              strobe_q;
  logic              accept, exec;

  step_req_t         req;
  entry_t            head_ent;
  ram_wr_t           wr;
  logic [PtrW-1:0]   rd_addr;
  out_t              step_res;

  // Control sequencer: idle until a beat arrives, then the update state (busy), then idle.
  always_comb begin
    state_d = state_q;
    busy    = 1'b0;
    exec    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy    = 1'b1;
        exec    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      limit_q  <= LimitReset;
    end else begin
      state_q  <= state_d;
      strobe_q <= exec;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // The input beat is held for the update cycle; results are registered.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (exec) begin
      result_q <= step_res;
    end
  end

  assign req.exec  = exec;
  assign req.item  = item_q;
  assign req.limit = limit_q;

  bqsm_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (head_ent)
  );

  bqsm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .head_i    (head_ent),
    .rd_addr_o (rd_addr),
    .wr_o      (wr),
    .result_o  (step_res)
  );

  assign strobe   = strobe_q;
  assign result_o = result_q;

  a_strobe_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> strobe)
    else $error("update cycle not followed by a result");

  a_accept_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted beat did not enter the update cycle");

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("update cycle lasted longer than one cycle");

endmodule : bounded_queue_service_monitor
`default_nettype wire

### tb/sv/tb_bounded_queue_service_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_queue_service_monitor
// Self-checking bench for the bounded queue service monitor. A table of
// directed ticks covers the queue limit extremes (zero, reset value, the full
// store and values above it), zero and maximum service times, and turned-away
// arrivals. After a drain, random phases follow, each under its own queue
// limit and traffic mix. Every tick is predicted in the bench and every
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bounded_queue_service_monitor;
  import bqsm_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumRows    = 28;
  localparam int NumPhases  = 10;
  localparam int PhaseTicks = 100;
  // Cycles to let pass after the last result before touching the register.
  localparam int SettleCycles = 4;

  // Kind of a directed table row: one tick, or a write of the queue limit.
  typedef enum logic {
    ROW_TICK,
    ROW_LIMIT
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              arrival;
    logic [SvcW-1:0]   svc;
    logic [LimitW-1:0] limit;
    logic              typed;  // the want field holds the expected result
    out_t              want;
  } row_t;

  // The first four ticks are simple enough to write down by hand. The rest
  // fill the queue to the reset limit, hit limit zero, push the store to its
  // full depth under a limit above the depth, and then sit at a limit of 16.
  localparam row_t DirectedRows [NumRows] = '{
    '{ROW_TICK,  1'b0, 8'h00, 5'd0,  1'b1, '{5'd0, 1'b0, 32'd0, 32'd0, 32'd0, 40'd0, 40'd0}},
    '{ROW_TICK,  1'b1, 8'h00, 5'd0,  1'b1, '{5'd0, 1'b1, 32'd1, 32'd1, 32'd0, 40'd0, 40'd0}},
    '{ROW_TICK,  1'b1, 8'hFF, 5'd0,  1'b1, '{5'd0, 1'b1, 32'd2, 32'd2, 32'd0, 40'd0, 40'd0}},
    '{ROW_TICK,  1'b1, 8'h0A, 5'd0,  1'b1, '{5'd1, 1'b0, 32'd3, 32'd2, 32'd0, 40'd1, 40'd0}},
    '{ROW_TICK,  1'b1, 8'h55, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h2A, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h01, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h02, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h04, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h08, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h10, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h03, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h00, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h80, 5'd0,  1'b0, '0},
    '{ROW_LIMIT, 1'b0, 8'h00, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h7F, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'hFF, 5'd0,  1'b0, '0},
    '{ROW_LIMIT, 1'b0, 8'h00, 5'd31, 1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h01, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h00, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h05, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h02, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h20, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h40, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b1, 8'h06, 5'd0,  1'b0, '0},
    '{ROW_LIMIT, 1'b0, 8'h00, 5'd16, 1'b0, '0},
    '{ROW_TICK,  1'b1, 8'hC3, 5'd0,  1'b0, '0},
    '{ROW_TICK,  1'b0, 8'h3C, 5'd0,  1'b0, '0}
  };

  // Queue limits of the random phases, extremes among them.
  localparam logic [LimitW-1:0] PhaseLimits [NumPhases] = '{
    5'd1, 5'd16, 5'd31, 5'd0, 5'd2, 5'd8, 5'd17, 5'd15, 5'd4, 5'd12
  };

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  in_t               item_i     = '0;
  logic              strobe;
  out_t              result_o;
  logic              cfg_we_i   = 1'b0;
  logic [LimitW-1:0] cfg_data_i = '0;

  bounded_queue_service_monitor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .strobe     (strobe),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Queue predictor. It mirrors the block's state: the entry store as two
  // arrays, the pointers, the occupancy, the tick stamp, the server countdown
  // and the saturating totals, plus its own copy of the queue limit.
  // --------------------------------------------------------------------------
  logic [StampW-1:0] slot_stamp   [QueueDepth];
  logic [SvcW-1:0]   slot_service [QueueDepth];
  logic [PtrW-1:0]   rd_idx       = '0;
  logic [PtrW-1:0]   wr_idx       = '0;
  logic [OccW-1:0]   held         = '0;
  logic [StampW-1:0] now_tick     = '0;
  logic [SvcW-1:0]   countdown    = '0;
  logic [CountW-1:0] n_accepted   = '0;
  logic [CountW-1:0] n_served     = '0;
  logic [CountW-1:0] n_rejected   = '0;
  logic [SumW-1:0]   len_acc      = '0;
  logic [SumW-1:0]   wait_acc     = '0;
  logic [LimitW-1:0] limit_cur    = LimitReset;

  // Results still owed by the block, oldest first.
  out_t report_q [$];
  int   mismatches  = 0;
  int   cycle_count = 0;
  bit   gaps_on     = 1'b1;

  function automatic logic [CountW-1:0] bump_count(input logic [CountW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [SumW-1:0] add_clamp(input logic [SumW-1:0] a,
                                                input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  function automatic logic [PtrW-1:0] wrap_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // One tick of the queue: enqueue or turn away, start service when the
  // server is free, count down, then accumulate length and advance time.
  function automatic out_t simulate_tick(input in_t beat);
    logic [LimitW-1:0] cap;
    logic [StampW-1:0] waited;
    logic              began;
    out_t              r;
    // A limit above the store depth behaves as the depth itself.
    cap   = (limit_cur > LimitW'(QueueDepth)) ? LimitW'(QueueDepth) : limit_cur;
    began = 1'b0;
    if (beat.arrival) begin
      if (LimitW'(held) >= cap) begin
        n_rejected = bump_count(n_rejected);
      end else begin
        slot_stamp[wr_idx]   = now_tick;
        slot_service[wr_idx] = beat.service_ticks;
        wr_idx               = wrap_ptr(wr_idx);
        held                 = held + 1'b1;
        n_accepted           = bump_count(n_accepted);
      end
    end
    if (countdown == '0 && held != '0) begin
      // A zero service time leaves the countdown at zero, so the server is
      // free again on the next tick.
      waited    = now_tick - slot_stamp[rd_idx];
      countdown = slot_service[rd_idx];
      rd_idx    = wrap_ptr(rd_idx);
      held      = held - 1'b1;
      wait_acc  = add_clamp(wait_acc, SumW'(waited));
      n_served  = bump_count(n_served);
      began     = 1'b1;
    end
    if (countdown != '0) begin
      countdown = countdown - 1'b1;
    end
    len_acc  = add_clamp(len_acc, SumW'(held));
    now_tick = bump_count(now_tick);

    r.queue_length      = LenW'(held);
    r.started_service   = began;
    r.accepted_count    = n_accepted;
    r.served_count      = n_served;
    r.turned_away_count = n_rejected;
    r.length_sum        = len_acc;
    r.wait_sum          = wait_acc;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side. Inputs move on the falling edge; a beat is taken at the
  // rising edge where start is high and busy is low. The caller's start stays
  // high across back-to-back ticks, so each tick assigns it once.
  // --------------------------------------------------------------------------
  task automatic drive_tick(input in_t beat, input bit typed, input out_t want);
    out_t predicted;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      // Idle with junk on the item bus.
      start  <= 1'b0;
      item_i <= in_t'($urandom);
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= beat;
    do @(posedge clk_i); while (busy);
    // The predictor always advances; a typed row overrides its result.
    predicted = simulate_tick(beat);
    report_q.push_back(typed ? want : predicted);
  endtask

  // The limit is only changed while nothing is outstanding.
  task automatic apply_limit(input logic [LimitW-1:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (report_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    limit_cur = value;
  endtask

  // --------------------------------------------------------------------------
  // Result side. The block never waits for the receiver, so every strobe is a
  // beat that must match the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic compare_report(input out_t got, input out_t want);
    if (got.queue_length !== want.queue_length) begin
      $error("queue_length: expected %0d, got %0d", want.queue_length, got.queue_length);
      mismatches++;
    end
    if (got.started_service !== want.started_service) begin
      $error("started_service: expected %0d, got %0d",
             want.started_service, got.started_service);
      mismatches++;
    end
    if (got.accepted_count !== want.accepted_count) begin
      $error("accepted_count: expected %0d, got %0d",
             want.accepted_count, got.accepted_count);
      mismatches++;
    end
    if (got.served_count !== want.served_count) begin
      $error("served_count: expected %0d, got %0d", want.served_count, got.served_count);
      mismatches++;
    end
    if (got.turned_away_count !== want.turned_away_count) begin
      $error("turned_away_count: expected %0d, got %0d",
             want.turned_away_count, got.turned_away_count);
      mismatches++;
    end
    if (got.length_sum !== want.length_sum) begin
      $error("length_sum: expected %0d, got %0d", want.length_sum, got.length_sum);
      mismatches++;
    end
    if (got.wait_sum !== want.wait_sum) begin
      $error("wait_sum: expected %0d, got %0d", want.wait_sum, got.wait_sum);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe) begin
      if (report_q.size() == 0) begin
        $error("result beat arrived with no tick outstanding");
        mismatches++;
      end else begin
        compare_report(result_o, report_q.pop_front());
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_t               beat;
    int unsigned       arrival_pct;
    int unsigned       svc_cap;
    logic [LimitW-1:0] lim;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int i = 0; i < NumRows; i++) begin
      if (DirectedRows[i].kind == ROW_LIMIT) begin
        lim = DirectedRows[i].limit;
        apply_limit(lim);
      end else begin
        beat.arrival       = DirectedRows[i].arrival;
        beat.service_ticks = DirectedRows[i].svc;
        drive_tick(beat, DirectedRows[i].typed, DirectedRows[i].want);
      end
    end

    // Let the full queue and the long service times drain before the random
    // phases, so that the first phase starts from an empty, idle server.
    while (held != '0 || countdown != '0) begin
      beat.arrival       = 1'b0;
      beat.service_ticks = SvcW'($urandom);
      drive_tick(beat, 1'b0, '0);
    end

    // Random phases: each picks a limit, an arrival rate and a typical
    // service length, with an occasional full-range service time. One phase
    // runs without idle cycles.
    for (int p = 0; p < NumPhases; p++) begin
      apply_limit(PhaseLimits[p]);
      gaps_on     = (p != 2);
      arrival_pct = $urandom_range(15, 95);
      case ($urandom_range(0, 2))
        0: svc_cap = 2;
        1: svc_cap = 6;
        default: svc_cap = 20;
      endcase
      for (int n = 0; n < PhaseTicks; n++) begin
        beat.arrival = ($urandom_range(0, 99) < arrival_pct);
        if ($urandom_range(0, 99) < 3) begin
          beat.service_ticks = SvcW'($urandom_range(0, 255));
        end else begin
          beat.service_ticks = SvcW'($urandom_range(0, svc_cap));
        end
        drive_tick(beat, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
